// ===== hdl/stencil_filter_3x3_macros.svh =====
// Assertion macros for the 3x3 stencil filter.
`ifndef STENCIL_FILTER_3X3_MACROS_SVH
`define STENCIL_FILTER_3X3_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SF3_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SF3_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SF3_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SF3_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/sf3_pkg.sv =====
`default_nettype none
package sf3_pkg;

  localparam int MAX_COLS_DEF = 1024;
  localparam int PIX_W        = 8;
  localparam int ROWS_W       = 13;
  localparam int COLS_W       = 11;
  localparam int ROWC_W       = 12;
  localparam int DIM_W        = 14;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int TOTAL_W      = 12;
  localparam int MIN_DIM      = 3;
  localparam int MAX_ROWS     = 4096;
  localparam int ROWS_RESET   = 480;
  localparam int COLS_RESET   = 640;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QLEVEL_W     = $clog2(QDEPTH + 1);
  localparam int RECIP_W      = 13;
  localparam int BOX_RECIP    = 7282;
  localparam int BOX_SHIFT    = 16;
  localparam int PROD_W       = TOTAL_W + RECIP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_MODE = 2'd2
  } sf3_reg_t;

  typedef enum logic {
    MODE_BOX  = 1'b0,
    MODE_EDGE = 1'b1
  } sf3_mode_t;

  typedef struct packed {
    logic [ROWS_W-1:0] rows;
    logic [COLS_W-1:0] cols;
    sf3_mode_t         mode;
  } sf3_cfg_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [PIX_W-1:0]   centre;
    logic               last;
  } sf3_item_t;

  typedef struct packed {
    logic f1_valid;
    logic push;
  } sf3_fstat_t;

endpackage
`default_nettype wire

// ===== hdl/sf3_front.sv =====
`default_nettype none
module sf3_front #(
  parameter int MAX_COLS = sf3_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sf3_pkg::sf3_cfg_t             cfg,
  input  logic                          restart,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sf3_pkg::PIX_W-1:0]     pixel_in,
  input  logic [sf3_pkg::QLEVEL_W-1:0]  q_level,
  output sf3_pkg::sf3_item_t            push_item,
  output sf3_pkg::sf3_fstat_t           fstat
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int DW = sf3_pkg::DIM_W;
  localparam int RW = sf3_pkg::ROWC_W;
  localparam int PW = sf3_pkg::PIX_W;

  logic [PW-1:0] top_mem [MAX_COLS];
  logic [PW-1:0] mid_mem [MAX_COLS];

  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic [DW-1:0] cols_ext, cols_eff, cols_last;
  logic [DW-1:0] rows_ext, rows_eff;
  logic [RW-1:0] rows_last;
  logic          accept;
  logic          at_col_end;
  logic          at_row_end;

  logic          f1_valid;
  logic [CW-1:0] f1_idx;
  logic [PW-1:0] f1_bot;
  logic          f1_interior;
  logic          f1_last;
  logic [PW-1:0] top_rd;
  logic [PW-1:0] mid_rd;
  logic [PW-1:0] win [6];
  logic [sf3_pkg::QLEVEL_W:0] occupancy;

  always_comb begin
    cols_ext = DW'(cfg.cols);
    if (cols_ext < DW'(sf3_pkg::MIN_DIM)) begin
      cols_eff = DW'(sf3_pkg::MIN_DIM);
    end else if (cols_ext > DW'(MAX_COLS)) begin
      cols_eff = DW'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
    cols_last = cols_eff - DW'(1);

    rows_ext = DW'(cfg.rows);
    if (rows_ext < DW'(sf3_pkg::MIN_DIM)) begin
      rows_eff = DW'(sf3_pkg::MIN_DIM);
    end else if (rows_ext > DW'(sf3_pkg::MAX_ROWS)) begin
      rows_eff = DW'(sf3_pkg::MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end
    rows_last = RW'(rows_eff - DW'(1));
  end

  assign occupancy  = (sf3_pkg::QLEVEL_W + 1)'(q_level) + (sf3_pkg::QLEVEL_W + 1)'(f1_valid);
  assign in_stall   = occupancy >= (sf3_pkg::QLEVEL_W + 1)'(sf3_pkg::QDEPTH);
  assign accept     = in_valid && !in_stall;
  assign at_col_end = DW'(col) == cols_last;
  assign at_row_end = row == rows_last;

  always_comb begin
    col_next = col;
    row_next = row;
    if (restart) begin
      col_next = '0;
      row_next = '0;
    end else if (accept) begin
      if (at_col_end) begin
        col_next = '0;
        row_next = at_row_end ? '0 : row + RW'(1);
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      f1_valid <= 1'b0;
    end else begin
      col      <= col_next;
      row      <= row_next;
      f1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_idx      <= col;
      f1_bot      <= pixel_in;
      f1_interior <= (row >= RW'(2)) && (col >= CW'(2));
      f1_last     <= at_row_end && at_col_end;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_rd       <= mid_mem[col];
      mid_mem[col] <= pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_rd <= top_mem[col];
    end
    if (f1_valid) begin
      top_mem[f1_idx] <= mid_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (f1_valid) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_rd;
      win[4] <= mid_rd;
      win[5] <= f1_bot;
    end
  end

  always_comb begin
    push_item.total = sf3_pkg::TOTAL_W'(win[0]) + sf3_pkg::TOTAL_W'(win[1])
                    + sf3_pkg::TOTAL_W'(win[2]) + sf3_pkg::TOTAL_W'(win[3])
                    + sf3_pkg::TOTAL_W'(win[4]) + sf3_pkg::TOTAL_W'(win[5])
                    + sf3_pkg::TOTAL_W'(top_rd) + sf3_pkg::TOTAL_W'(mid_rd)
                    + sf3_pkg::TOTAL_W'(f1_bot);
    push_item.centre = win[4];
    push_item.last   = f1_last;
    fstat.f1_valid   = f1_valid;
    fstat.push       = f1_valid && f1_interior;
  end

endmodule
`default_nettype wire

// ===== hdl/sf3_queue.sv =====
`default_nettype none
module sf3_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  sf3_pkg::sf3_item_t            push_item,
  input  logic                          pop,
  output sf3_pkg::sf3_item_t            head,
  output logic [sf3_pkg::QLEVEL_W-1:0]  level
);

  localparam int PW = sf3_pkg::QPTR_W;

  sf3_pkg::sf3_item_t entries [sf3_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(sf3_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(sf3_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      level <= level + sf3_pkg::QLEVEL_W'(push) - sf3_pkg::QLEVEL_W'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sf3_back.sv =====
`default_nettype none
module sf3_back (
  input  logic                          clk,
  input  logic                          rst,
  input  sf3_pkg::sf3_mode_t            mode,
  input  sf3_pkg::sf3_item_t            head,
  input  logic [sf3_pkg::QLEVEL_W-1:0]  q_level,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sf3_pkg::PIX_W-1:0]     pixel_out,
  output logic                          frame_last
);

  localparam int TW = sf3_pkg::TOTAL_W;
  localparam int PW = sf3_pkg::PIX_W;

  logic [sf3_pkg::PROD_W-1:0] prod;
  logic [PW-1:0]              box_val;
  logic [TW-1:0]              c8;
  logic [TW-1:0]              nb;
  logic [TW-1:0]              diff;
  logic [PW-1:0]              edge_val;
  logic [PW-1:0]              result;

  assign pop = (q_level != '0) && (!out_valid || !out_stall);

  always_comb begin
    prod     = sf3_pkg::PROD_W'(head.total)
             * sf3_pkg::PROD_W'(sf3_pkg::BOX_RECIP);
    box_val  = prod[sf3_pkg::BOX_SHIFT +: PW];
    c8       = TW'({head.centre, 3'b000});
    nb       = head.total - TW'(head.centre);
    diff     = (c8 >= nb) ? (c8 - nb) : (nb - c8);
    edge_val = (diff > TW'(255)) ? 8'hFF : diff[PW-1:0];
    case (mode)
      sf3_pkg::MODE_BOX:  result = box_val;
      sf3_pkg::MODE_EDGE: result = edge_val;
      default:            result = box_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pixel_out  <= result;
      frame_last <= head.last;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/stencil_filter_3x3.sv =====
// 3x3 stencil filter over an 8-bit grayscale frame streamed in raster order. One pixel
// per clock is taken while in_stall is low; the front end reads and writes both line
// stores once per pixel, so that single memory port pair sets the rate at one pixel a
// cycle. Once the pixel completing its window is taken, the result for an interior
// pixel passes in order through the line store read with window sum, the queue and the
// filter, and a four-entry queue decouples the filter stage, so the input stalls only
// once the queue and the window stage hold four beats between them. Border pixels give
// no beat; the final interior beat of a frame has frame_last set. The line stores have
// no clearing pass and reset takes effect at once. A write to the rows, cols or mode
// register restarts the frame at row 0, column 0; cfg_ready is always high.
`default_nettype none
`include "stencil_filter_3x3_macros.svh"
module stencil_filter_3x3 #(
  parameter int MAX_COLS = sf3_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sf3_pkg::PIX_W-1:0]        pixel_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sf3_pkg::PIX_W-1:0]        pixel_out,
  output logic                             frame_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sf3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sf3_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sf3_pkg::sf3_cfg_t                cfg;
  sf3_pkg::sf3_item_t               push_item;
  sf3_pkg::sf3_item_t               head;
  sf3_pkg::sf3_fstat_t              fstat;
  logic [sf3_pkg::QLEVEL_W-1:0]     q_level;
  logic                             q_pop;
  logic                             cfg_we;
  logic                             restart;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    case (sf3_pkg::sf3_reg_t'(cfg_index))
      sf3_pkg::REG_ROWS: restart = cfg_we;
      sf3_pkg::REG_COLS: restart = cfg_we;
      sf3_pkg::REG_MODE: restart = cfg_we;
      default:           restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows <= sf3_pkg::ROWS_W'(sf3_pkg::ROWS_RESET);
      cfg.cols <= sf3_pkg::COLS_W'(sf3_pkg::COLS_RESET);
      cfg.mode <= sf3_pkg::MODE_BOX;
    end else if (cfg_we) begin
      case (sf3_pkg::sf3_reg_t'(cfg_index))
        sf3_pkg::REG_ROWS: cfg.rows <= cfg_data;
        sf3_pkg::REG_COLS: cfg.cols <= cfg_data[sf3_pkg::COLS_W-1:0];
        sf3_pkg::REG_MODE: cfg.mode <= sf3_pkg::sf3_mode_t'(cfg_data[0]);
        default: begin
        end
      endcase
    end
  end

  sf3_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .restart   (restart),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel_in  (pixel_in),
    .q_level   (q_level),
    .push_item (push_item),
    .fstat     (fstat)
  );

  sf3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fstat.push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (head),
    .level     (q_level)
  );

  sf3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mode       (cfg.mode),
    .head       (head),
    .q_level    (q_level),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

  `SF3_ASSERT_IMP(a_accept_room, clk, rst, in_valid && !in_stall, (q_level + fstat.f1_valid) < sf3_pkg::QDEPTH, "pixel accepted without a reserved queue slot")
  `SF3_ASSERT_IMP(a_no_overflow, clk, rst, fstat.push, (q_level < sf3_pkg::QDEPTH) || q_pop, "push into a full queue")
  `SF3_ASSERT_IMP(a_no_underflow, clk, rst, q_pop, q_level != 0, "pop from an empty queue")
  `SF3_ASSERT_NXT(a_push_lands, clk, rst, fstat.push, q_level != 0, "pushed beat missing from queue")

endmodule
`default_nettype wire
